// ===== rtl/tzts_pkg.sv =====
// Shared types and codes for the thermal zone throttle selector.
// Holds the transaction structs, zone table entry, sequencer states and codes.
// No dependencies.
package tzts_pkg;

   localparam int FREQ_WIDTH      = 24;
   localparam int TEMP_WIDTH      = 16;
   localparam int ZONE_IDX_WIDTH  = 4;
   localparam int ZONE_OUT_WIDTH  = 5;
   localparam int CSR_INDEX_WIDTH = 2;

   // operation codes
   localparam logic [1:0] OP_WRITE      = 2'd0;
   localparam logic [1:0] OP_SAMPLE     = 2'd1;
   localparam logic [1:0] OP_UNTHROTTLE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_USER_MAX      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LITTLE_HW_MAX = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIG_HW_MAX    = 2'd2;

   typedef struct packed {
      logic [1:0]                   operation;
      logic [ZONE_IDX_WIDTH-1:0]    zone_index;
      logic [FREQ_WIDTH-1:0]        zone_little_freq;
      logic [FREQ_WIDTH-1:0]        zone_big_freq;
      logic signed [TEMP_WIDTH-1:0] zone_trip_temp;
      logic signed [TEMP_WIDTH-1:0] zone_reset_temp;
      logic signed [TEMP_WIDTH-1:0] temperature;
   } req_type;

   typedef struct packed {
      logic signed [ZONE_OUT_WIDTH-1:0] zone;
      logic                             zone_changed;
      logic [FREQ_WIDTH-1:0]            little_throttle_freq;
      logic [FREQ_WIDTH-1:0]            big_throttle_freq;
      logic [FREQ_WIDTH-1:0]            little_max_freq;
      logic [FREQ_WIDTH-1:0]            big_max_freq;
   } rsp_type;

   typedef struct packed {
      logic [FREQ_WIDTH-1:0]        little_freq;
      logic [FREQ_WIDTH-1:0]        big_freq;
      logic signed [TEMP_WIDTH-1:0] trip_temp;
      logic signed [TEMP_WIDTH-1:0] reset_temp;
   } zone_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/tzts_zone_table.sv =====
// Zone table: one write port, two registered read ports, valid bit per entry.
// Unwritten entries read as all zero. Depends on tzts_pkg.
module tzts_zone_table
   import tzts_pkg::*;
#(
   parameter int ZONE_COUNT = 12,
   parameter int IW         = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [IW-1:0]                wr_addr,
   input  zone_entry_type               wr_data,
   input  logic [IW:0]                  rd_a_addr,
   input  logic [IW:0]                  rd_b_addr,
   output zone_entry_type               rd_a_data,
   output logic signed [TEMP_WIDTH-1:0] rd_b_trip
);

   zone_entry_type               entry_mem [ZONE_COUNT];
   logic [ZONE_COUNT-1:0]        valid_ff;
   zone_entry_type               rd_a_q_ff;
   logic signed [TEMP_WIDTH-1:0] rd_b_trip_ff;
   logic                         rd_a_hit_ff;
   logic                         rd_b_hit_ff;
   logic                         rd_a_in_range;
   logic                         rd_b_in_range;

   assign rd_a_in_range = rd_a_addr < (IW+1)'(ZONE_COUNT);
   assign rd_b_in_range = rd_b_addr < (IW+1)'(ZONE_COUNT);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_a_in_range) begin
         rd_a_q_ff <= entry_mem[rd_a_addr[IW-1:0]];
      end
      if (rd_b_in_range) begin
         rd_b_trip_ff <= entry_mem[rd_b_addr[IW-1:0]].trip_temp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_a_hit_ff <= 1'b0;
         rd_b_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_a_hit_ff <= rd_a_in_range && valid_ff[rd_a_addr[IW-1:0]];
         rd_b_hit_ff <= rd_b_in_range && valid_ff[rd_b_addr[IW-1:0]];
      end
   end

   assign rd_a_data = rd_a_hit_ff ? rd_a_q_ff : '0;
   assign rd_b_trip = rd_b_hit_ff ? rd_b_trip_ff : '0;

endmodule

// ===== rtl/thermal_zone_throttle_selector.sv =====
// Thermal zone throttle selector, top level.
// Sequencer, zone evaluator and result register. Depends on tzts_pkg, tzts_zone_table.
//
// The block holds a table of ZONE_COUNT thermal zones, each with a little and a
// big cluster frequency cap, a trip and a reset temperature; all entries are
// zero after reset and a zone with a zero little cap ends the table. A write
// transaction (operation 0) loads one entry; a zone_index at or beyond
// ZONE_COUNT is dropped. A sample transaction (operation 1) walks the zones in
// order with one shared evaluator under a small sequencer, one zone per cycle,
// applying the trip/reset hysteresis, and picks the new zone or the
// unthrottled state (-1) and the throttle frequencies that go with it. An
// unthrottle transaction (operation 2) clears the throttle frequencies and keeps
// the zone; operation 3 only reports the state. Every transaction yields one
// result: zone, changed flag (samples only), throttle frequencies and per-cluster
// policy maximums, combined with the user and hardware ceilings held in the csr
// registers. A write, unthrottle or unused operation goes from idle to the
// finish state; a sample passes through the prime state and then walks the
// table, visiting from one to ZONE_COUNT zones, before the finish state. The
// result register is loaded in the finish state once the output is free, and
// the input is ready again in the cycle in which the result appears. The
// result sits in an output register, so the next transaction is taken while
// it waits.
// Registers may be written only while the block is idle.
module thermal_zone_throttle_selector
   import tzts_pkg::*;
#(
   parameter int ZONE_COUNT = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [FREQ_WIDTH-1:0]      csr_wdata
);

   localparam int IW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
   localparam int ZW = IW + 1;   // signed zone, -1 = unthrottled

   // policy maximum: user ceiling under a throttle cap, else user or hw
   function automatic logic [FREQ_WIDTH-1:0] policy_max(
      input logic [FREQ_WIDTH-1:0] thr,
      input logic [FREQ_WIDTH-1:0] user,
      input logic [FREQ_WIDTH-1:0] hw
   );
      logic [FREQ_WIDTH-1:0] res;
      if (thr != '0) begin
         res = (user != '0 && user < thr) ? user : thr;
      end else begin
         res = (user != '0) ? user : hw;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- state
   state_type                    state_ff, state_in;
   logic [ZW-1:0]                zone_ff;
   logic [FREQ_WIDTH-1:0]        thr_little_ff;
   logic [FREQ_WIDTH-1:0]        thr_big_ff;
   logic                         changed_ff;
   logic [IW-1:0]                eval_idx_ff;
   logic [FREQ_WIDTH-1:0]        prev_little_ff;
   logic [FREQ_WIDTH-1:0]        prev_big_ff;
   logic signed [TEMP_WIDTH-1:0] temp_ff;
   logic [FREQ_WIDTH-1:0]        user_max_ff;
   logic [FREQ_WIDTH-1:0]        little_hw_max_ff;
   logic [FREQ_WIDTH-1:0]        big_hw_max_ff;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_data_ff;

   // ---------------------------------------------------------------- control
   logic                         req_fire;
   logic                         load_rsp;
   logic                         walk_active;
   logic                         table_wr_en;
   logic [IW-1:0]                table_wr_addr;
   zone_entry_type               table_wr_data;
   logic [IW:0]                  rd_a_addr;
   logic [IW:0]                  rd_b_addr;
   zone_entry_type               cur_entry;
   logic signed [TEMP_WIDTH-1:0] next_trip;

   // ---------------------------------------------------------------- evaluator
   logic signed [TEMP_WIDTH-1:0] cur_trip;
   logic signed [TEMP_WIDTH-1:0] cur_reset;
   logic                         old_unthrottled;
   logic                         first_zone;
   logic                         last_zone;
   logic                         walk_stop;
   logic [ZW-1:0]                new_zone;
   logic [FREQ_WIDTH-1:0]        new_little;
   logic [FREQ_WIDTH-1:0]        new_big;
   logic [ZW-1:0]                cur_zone;

   logic signed [31:0]           zone_ext;

   // zone table
   assign table_wr_addr             = IW'(req_data.zone_index);
   assign table_wr_data.little_freq = req_data.zone_little_freq;
   assign table_wr_data.big_freq    = req_data.zone_big_freq;
   assign table_wr_data.trip_temp   = req_data.zone_trip_temp;
   assign table_wr_data.reset_temp  = req_data.zone_reset_temp;

   tzts_zone_table #(
      .ZONE_COUNT (ZONE_COUNT),
      .IW         (IW)
   ) u_zone_table (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (table_wr_en),
      .wr_addr   (table_wr_addr),
      .wr_data   (table_wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (cur_entry),
      .rd_b_trip (next_trip)
   );

   // control outputs of the sequencer
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      walk_active = (state_ff == ST_WALK);
      load_rsp    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
      if (state_ff == ST_PRIME) begin
         rd_a_addr = '0;
         rd_b_addr = (IW+1)'(1);
      end else begin
         // fetch one zone ahead of the one being evaluated
         rd_a_addr = {1'b0, eval_idx_ff} + (IW+1)'(1);
         rd_b_addr = {1'b0, eval_idx_ff} + (IW+1)'(2);
      end
   end

   assign req_fire    = req_valid && req_ready;
   assign table_wr_en = req_fire && (req_data.operation == OP_WRITE) &&
                        (int'(req_data.zone_index) < ZONE_COUNT);

   // hysteresis step on the zone held in the read register
   assign cur_trip        = cur_entry.trip_temp;
   assign cur_reset       = cur_entry.reset_temp;
   assign old_unthrottled = &zone_ff;
   assign first_zone      = (eval_idx_ff == '0);
   assign last_zone       = (eval_idx_ff == IW'(ZONE_COUNT - 1));
   assign cur_zone        = {1'b0, eval_idx_ff};

   always_comb begin
      walk_stop  = 1'b0;
      new_zone   = cur_zone;
      new_little = cur_entry.little_freq;
      new_big    = cur_entry.big_freq;
      if (cur_entry.little_freq == '0) begin
         // end of table: previous zone, or unthrottled at zone 0
         walk_stop  = 1'b1;
         new_zone   = cur_zone - ZW'(1);
         new_little = prev_little_ff;
         new_big    = prev_big_ff;
      end else if (last_zone) begin
         walk_stop = 1'b1;
      end else if (temp_ff > cur_reset) begin
         if (temp_ff < next_trip && (temp_ff >= cur_trip || !old_unthrottled)) begin
            walk_stop = 1'b1;
         end else if (first_zone && old_unthrottled && temp_ff < cur_trip) begin
            // below first trip while unthrottled: stay unthrottled
            walk_stop  = 1'b1;
            new_zone   = '1;
            new_little = '0;
            new_big    = '0;
         end
      end else if (first_zone) begin
         walk_stop  = 1'b1;
         new_zone   = '1;
         new_little = '0;
         new_big    = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_data.operation == OP_SAMPLE) ? ST_PRIME : ST_FINISH;
            end
         end
         ST_PRIME: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_stop) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         zone_ff          <= '1;
         thr_little_ff    <= '0;
         thr_big_ff       <= '0;
         user_max_ff      <= '0;
         little_hw_max_ff <= '1;
         big_hw_max_ff    <= '1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_USER_MAX:      user_max_ff      <= csr_wdata;
               CSR_LITTLE_HW_MAX: little_hw_max_ff <= csr_wdata;
               CSR_BIG_HW_MAX:    big_hw_max_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_fire && req_data.operation == OP_UNTHROTTLE) begin
            thr_little_ff <= '0;
            thr_big_ff    <= '0;
         end
         if (walk_active && walk_stop) begin
            zone_ff       <= new_zone;
            thr_little_ff <= new_little;
            thr_big_ff    <= new_big;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // walk and result payload registers
   assign zone_ext = 32'(signed'(zone_ff));

   always_ff @(posedge clock) begin
      if (req_fire) begin
         temp_ff        <= req_data.temperature;
         eval_idx_ff    <= '0;
         prev_little_ff <= '0;
         prev_big_ff    <= '0;
         changed_ff     <= 1'b0;
      end
      if (walk_active) begin
         if (walk_stop) begin
            changed_ff <= (new_zone != zone_ff);
         end else begin
            eval_idx_ff    <= eval_idx_ff + IW'(1);
            prev_little_ff <= cur_entry.little_freq;
            prev_big_ff    <= cur_entry.big_freq;
         end
      end
      if (load_rsp) begin
         rsp_data_ff.zone                 <= zone_ext[ZONE_OUT_WIDTH-1:0];
         rsp_data_ff.zone_changed         <= changed_ff;
         rsp_data_ff.little_throttle_freq <= thr_little_ff;
         rsp_data_ff.big_throttle_freq    <= thr_big_ff;
         rsp_data_ff.little_max_freq      <= policy_max(thr_little_ff, user_max_ff,
                                                        little_hw_max_ff);
         rsp_data_ff.big_max_freq         <= policy_max(thr_big_ff, user_max_ff,
                                                        big_hw_max_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/tzts_checker.sv =====
// Port-level checks for the thermal zone throttle selector, with its bind.
// Depends on tzts_pkg and thermal_zone_throttle_selector.
module tzts_checker
   import tzts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a transaction is never taken back to back with the one before
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken in consecutive cycles");

   // unthrottled state carries no throttle frequency
   a_unthrottled_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zone == '1 |->
         rsp_data.little_throttle_freq == '0 && rsp_data.big_throttle_freq == '0)
      else $error("throttle frequency while unthrottled");

   // the little policy maximum never exceeds an active throttle cap
   a_cap_respected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.little_throttle_freq != '0 |->
         rsp_data.little_max_freq <= rsp_data.little_throttle_freq)
      else $error("little maximum above throttle cap");

endmodule

bind thermal_zone_throttle_selector tzts_checker u_tzts_checker (.*);
